// File: src/bsa4_pkg.sv
// Shared types and constants for the 4-bit bit-slice ALU.
`default_nettype none
package bsa4_pkg;

	localparam int unsigned NIB_W = 4;

	// Source operand pairs, R then S
	typedef enum logic [2:0] {
		SRC_AQ = 3'd0,
		SRC_AB = 3'd1,
		SRC_ZQ = 3'd2,
		SRC_ZB = 3'd3,
		SRC_ZA = 3'd4,
		SRC_DA = 3'd5,
		SRC_DQ = 3'd6,
		SRC_DZ = 3'd7
	} src_t;

	typedef enum logic [2:0] {
		FN_ADD   = 3'd0,
		FN_SUBR  = 3'd1,
		FN_SUBS  = 3'd2,
		FN_OR    = 3'd3,
		FN_AND   = 3'd4,
		FN_NOTRS = 3'd5,
		FN_EXOR  = 3'd6,
		FN_EXNOR = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		DST_QREG  = 3'd0,
		DST_NOP   = 3'd1,
		DST_RAMA  = 3'd2,
		DST_RAMF  = 3'd3,
		DST_RAMQD = 3'd4,
		DST_RAMD  = 3'd5,
		DST_RAMQU = 3'd6,
		DST_RAMU  = 3'd7
	} dest_t;

	// ALU result and flags handed from the ALU to the top level
	typedef struct packed {
		logic [NIB_W-1:0] f;
		logic             carry;
		logic             ovr;
		logic             pn;
		logic             gn;
	} alu_res_t;

endpackage
`default_nettype wire

// File: src/bsa4_alu.sv
// Eight-function 4-bit ALU with carry, overflow and lookahead outputs.
`default_nettype none
module bsa4_alu (
	input  wire logic [bsa4_pkg::NIB_W-1:0] r,
	input  wire logic [bsa4_pkg::NIB_W-1:0] s,
	input  wire bsa4_pkg::func_t            func,
	input  wire logic                       cn,
	output bsa4_pkg::alu_res_t              res
);

	logic [bsa4_pkg::NIB_W-1:0] ri, si, p, g;
	logic c1, c2, c3, c4, pall, gany, gsum, t, u, v;

	always_comb begin
		ri = r;
		si = s;
		if (func == bsa4_pkg::FN_SUBR || func == bsa4_pkg::FN_NOTRS ||
				func == bsa4_pkg::FN_EXOR)
			ri = ~r;
		if (func == bsa4_pkg::FN_SUBS)
			si = ~s;
	end

	assign p    = ri | si;
	assign g    = ri & si;
	assign pall = &p;
	assign gany = |g;
	assign c1   = g[0] | (p[0] & cn);
	assign c2   = g[1] | (p[1] & c1);
	assign c3   = g[2] | (p[2] & c2);
	assign c4   = g[3] | (p[3] & c3);
	// upper three terms of the group generate
	assign gsum = g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1]);

	// overflow terms of the exclusive functions
	assign t = ~p[2] | (~g[2] & ~p[1]) | (~g[2] & ~g[1] & ~p[0])
		| (~g[2] & ~g[1] & ~g[0] & cn);
	assign u = ~g[3] & ~g[2] & ~g[1];
	assign v = ~p[3] | (~g[3] & ~p[2]) | (~g[3] & ~g[2] & ~p[1])
		| (u & ~p[0]) | (u & ~g[0] & cn);

	always_comb begin
		res = '0;
		case (func)
			bsa4_pkg::FN_ADD, bsa4_pkg::FN_SUBR, bsa4_pkg::FN_SUBS: begin
				res.f     = ri ^ si ^ {c3, c2, c1, cn};
				res.pn    = ~pall;
				res.gn    = ~(gsum | (p[3] & p[2] & p[1] & g[0]));
				res.carry = c4;
				res.ovr   = c3 ^ c4;
			end
			bsa4_pkg::FN_OR: begin
				res.f     = p;
				res.pn    = 1'b0;
				res.gn    = pall;
				res.carry = ~pall | cn;
				res.ovr   = ~pall | cn;
			end
			bsa4_pkg::FN_AND, bsa4_pkg::FN_NOTRS: begin
				res.f     = g;
				res.pn    = 1'b0;
				res.gn    = ~gany;
				res.carry = gany | cn;
				res.ovr   = gany | cn;
			end
			default: begin
				res.f     = ~(ri ^ si);
				res.pn    = gany;
				res.gn    = gsum | pall;
				res.carry = ~(gsum | (pall & (g[0] | ~cn)));
				res.ovr   = t ^ v;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: src/bit_slice_alu_4bit.sv
// Top level of the 4-bit bit-slice ALU: register file, Q register and pipeline.
//
// One microinstruction per input beat on s_axis; one result beat per
// microinstruction on m_axis, in order.
// Pipeline: an accepted beat lands in the stage-1 register together with the
// register-file words A and B, read at acceptance. During stage 1 the ALU and
// shifters run, the register file and Q are written back, and the result is
// loaded into the output register, which offers it on m_axis. One beat can be
// accepted every cycle while m_axis_tready is high or the output is empty.
// A stage-1 write to the register file is forwarded to the read of the beat
// being accepted in the same cycle, so back-to-back dependent beats see the
// updated words.
// Stall: while m_axis_tready is low, the output register holds its beat, the
// stage-1 beat waits with no write-back, and s_axis_tready drops once both
// are full.
// Reset clears the pipeline valids, the Q register and the register-file
// valid bits, so every register-file word reads as zero until written.
`default_nettype none
module bit_slice_alu_4bit #(
	parameter int unsigned REG_COUNT = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [2:0] src, [5:3] func, [8:6] dest, [12:9] addr_a, [16:13] addr_b,
	// [20:17] d_in, [21] carry_in, [22] out_enable_n, [23] ram_shift_in,
	// [24] q_shift_in, [31:25] zero
	input  wire logic [31:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [3:0] y_out, [4] y_driven, [5] carry_out, [6] overflow, [7] sign_bit,
	// [8] zero_flag, [9] prop_n, [10] gen_n, [11] ram_shift_out,
	// [12] q_shift_out, [15:13] zero
	output logic [15:0]      m_axis_tdata
);

	localparam int unsigned AW = $clog2(REG_COUNT);
	localparam int unsigned NW = bsa4_pkg::NIB_W;

	// unpack the incoming beat
	bsa4_pkg::src_t  in_src;
	bsa4_pkg::func_t in_func;
	bsa4_pkg::dest_t in_dest;
	logic [AW-1:0]   in_addr_a, in_addr_b;

	assign in_src    = bsa4_pkg::src_t'(s_axis_tdata[2:0]);
	assign in_func   = bsa4_pkg::func_t'(s_axis_tdata[5:3]);
	assign in_dest   = bsa4_pkg::dest_t'(s_axis_tdata[8:6]);
	assign in_addr_a = s_axis_tdata[9 +: AW];
	assign in_addr_b = s_axis_tdata[13 +: AW];

	// stage 1 registers
	logic            valid_s1;
	bsa4_pkg::src_t  src_s1;
	bsa4_pkg::func_t func_s1;
	bsa4_pkg::dest_t dest_s1;
	logic [AW-1:0]   addr_b_s1;
	logic [NW-1:0]   d_s1, a_s1, b_s1;
	logic            cn_s1, oe_n_s1, rsi_s1, qsi_s1;

	// state
	logic [NW-1:0]        reg_file_q [REG_COUNT];
	logic [REG_COUNT-1:0] rf_valid_q;
	logic [NW-1:0]        q_q;

	// output register
	logic        out_valid_q;
	logic [15:0] out_data_q;

	logic s_fire, advance, fire_s1;

	// stage 1 moves on when the output register is free or being emptied
	assign advance       = !out_valid_q || m_axis_tready;
	assign fire_s1       = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	// operand selection
	logic [NW-1:0] r_op, s_op;

	always_comb begin
		r_op = '0;
		s_op = '0;
		case (src_s1)
			bsa4_pkg::SRC_AQ: begin r_op = a_s1; s_op = q_q;  end
			bsa4_pkg::SRC_AB: begin r_op = a_s1; s_op = b_s1; end
			bsa4_pkg::SRC_ZQ: begin r_op = '0;   s_op = q_q;  end
			bsa4_pkg::SRC_ZB: begin r_op = '0;   s_op = b_s1; end
			bsa4_pkg::SRC_ZA: begin r_op = '0;   s_op = a_s1; end
			bsa4_pkg::SRC_DA: begin r_op = d_s1; s_op = a_s1; end
			bsa4_pkg::SRC_DQ: begin r_op = d_s1; s_op = q_q;  end
			default:          begin r_op = d_s1; s_op = '0;   end
		endcase
	end

	bsa4_pkg::alu_res_t alu;

	bsa4_alu u_alu (
		.r    (r_op),
		.s    (s_op),
		.func (func_s1),
		.cn   (cn_s1),
		.res  (alu)
	);

	// destination decode: write-back and shift-out bits
	logic          rf_we, q_we, rso, qso;
	logic [NW-1:0] rf_wdata, q_wdata, y_val;

	always_comb begin
		rf_we    = 1'b0;
		q_we     = 1'b0;
		rf_wdata = alu.f;
		q_wdata  = alu.f;
		rso      = 1'b0;
		qso      = 1'b0;
		case (dest_s1)
			bsa4_pkg::DST_QREG: q_we = 1'b1;
			bsa4_pkg::DST_NOP:  ;
			bsa4_pkg::DST_RAMA, bsa4_pkg::DST_RAMF: rf_we = 1'b1;
			bsa4_pkg::DST_RAMQD, bsa4_pkg::DST_RAMD: begin
				rf_we    = 1'b1;
				rf_wdata = {rsi_s1, alu.f[NW-1:1]};
				q_we     = (dest_s1 == bsa4_pkg::DST_RAMQD);
				q_wdata  = {qsi_s1, q_q[NW-1:1]};
				rso      = alu.f[0];
				qso      = q_q[0];
			end
			default: begin
				rf_we    = 1'b1;
				rf_wdata = {alu.f[NW-2:0], rsi_s1};
				q_we     = (dest_s1 == bsa4_pkg::DST_RAMQU);
				q_wdata  = {q_q[NW-2:0], qsi_s1};
				rso      = alu.f[NW-1];
				qso      = q_q[NW-1];
			end
		endcase
	end

	assign y_val = (dest_s1 == bsa4_pkg::DST_RAMA) ? a_s1 : alu.f;

	logic wr_now;
	assign wr_now = fire_s1 && rf_we;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// stage 1 payload and registered register-file read, forwarding this cycle's write
	always_ff @(posedge clk) begin
		if (s_fire) begin
			src_s1    <= in_src;
			func_s1   <= in_func;
			dest_s1   <= in_dest;
			addr_b_s1 <= in_addr_b;
			d_s1      <= s_axis_tdata[20:17];
			cn_s1     <= s_axis_tdata[21];
			oe_n_s1   <= s_axis_tdata[22];
			rsi_s1    <= s_axis_tdata[23];
			qsi_s1    <= s_axis_tdata[24];
			if (wr_now && addr_b_s1 == in_addr_a)
				a_s1 <= rf_wdata;
			else
				a_s1 <= rf_valid_q[in_addr_a] ? reg_file_q[in_addr_a] : '0;
			if (wr_now && addr_b_s1 == in_addr_b)
				b_s1 <= rf_wdata;
			else
				b_s1 <= rf_valid_q[in_addr_b] ? reg_file_q[in_addr_b] : '0;
		end
	end

	// register file write port
	always_ff @(posedge clk) begin
		if (wr_now)
			reg_file_q[addr_b_s1] <= rf_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q <= '0;
			q_q        <= '0;
		end else if (fire_s1) begin
			if (rf_we)
				rf_valid_q[addr_b_s1] <= 1'b1;
			if (q_we)
				q_q <= q_wdata;
		end
	end

	// output register: load on advance, hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_data_q <= {3'b000, qso, rso, alu.gn, alu.pn, (alu.f == '0),
				alu.f[NW-1], alu.ovr, alu.carry, !oe_n_s1,
				(oe_n_s1 ? {NW{1'b0}} : y_val)};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// input side only blocks when both stages are full and the output stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled with a free stage");

	// a write forwarded to the beat accepted in the same cycle lands in A
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && wr_now && addr_b_s1 == in_addr_a) |=> (a_s1 == $past(rf_wdata)))
		else $error("register-file forwarding to A lost");

	// Q only changes when a stage-1 beat fires
	assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(q_q))
		else $error("Q register changed without a beat");

	// stalled stage 1 must not write the register file
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> $stable(rf_valid_q))
		else $error("register file written during a stall");

endmodule
`default_nettype wire
